// File: hdl/ksp_pkg.sv
package ksp_pkg;

	localparam logic [1:0] FUNC_LOAD_KEY  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_ELEM = 2'd1;
	localparam logic [1:0] FUNC_SORT      = 2'd2;
	localparam logic [1:0] FUNC_READ      = 2'd3;

	localparam logic CFG_NUM_KEYS = 1'b0;
	localparam logic CFG_NUM_ROWS = 1'b1;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         position;
		logic [5:0]         row_index;
		logic               read_matrix;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic               sort_done;
	} rsp_t;

endpackage

// File: hdl/ksp_order_map.sv
// Permutation store: two registered read ports, one write port.
// An entry never written since reset reads as its own index.
module ksp_order_map #(
	parameter int N  = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [AW-1:0] rd_data_a,
	output logic [AW-1:0] rd_data_b,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_data
);

	logic [AW-1:0] mem [N];
	logic [N-1:0]  vld_q;
	logic [AW-1:0] mem_a_q, mem_b_q, addr_a_q, addr_b_q;
	logic          vld_a_q, vld_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_a_q  <= mem[rd_addr_a];
			mem_b_q  <= mem[rd_addr_b];
			addr_a_q <= rd_addr_a;
			addr_b_q <= rd_addr_b;
			vld_a_q  <= vld_q[rd_addr_a];
			vld_b_q  <= vld_q[rd_addr_b];
		end
	end

	// fall back to identity for entries not yet written
	assign rd_data_a = vld_a_q ? mem_a_q : addr_a_q;
	assign rd_data_b = vld_b_q ? mem_b_q : addr_b_q;

endmodule

// File: hdl/key_sort_with_column_payload_unit.sv
// Key sort with column payload.
// Input channel (in_valid/in_ready/in_beat) takes commands: load key, load
// matrix element, sort, read. Output channel (out_valid/out_ready/out_beat)
// returns one beat per sort (data 0, sort_done 1) and one per read.
// Loads return nothing. Configuration goes through cfg_we/cfg_index/cfg_wdata
// and must be written only while the unit is idle; the unit itself does not
// enforce this. num_rows is accepted but does not change any answer since
// every row travels with its column. Timing: loads stream at one beat per
// cycle while the unit is idle; a read or sort in progress holds them off.
// A read passes through the order map read, the data read and the result
// register. A sort with n active keys runs about ceil(log2 n) merge passes:
// each merges every element through an order map read, a key read, and a
// compare and scratch write, then copies the scratch back to the order map.
// Reset clears the sequencer, the output valid flag and the order map valid
// bits (identity order); key and element stores hold garbage until loaded.
// A stalled receiver holds the result register; the unit keeps accepting
// loads meanwhile and waits to finish the next read or sort until the
// result register frees.
module key_sort_with_column_payload_unit #(
	parameter int MAX_KEYS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ksp_pkg::cmd_t   in_beat,
	output logic            out_valid,
	input  logic            out_ready,
	output ksp_pkg::rsp_t   out_beat,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [6:0]      cfg_wdata
);

	localparam int KW  = $clog2(MAX_KEYS);
	localparam int CW  = KW + 2;
	localparam int EAW = (MAX_ROWS * MAX_KEYS > 1) ? $clog2(MAX_ROWS * MAX_KEYS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SORT_INIT, ST_SEG, ST_M_OM, ST_M_KEY, ST_M_CMP,
		ST_CP_RD, ST_CP_WR, ST_SORT_DONE, ST_RD_OM, ST_RD_DAT
	} state_t;

	state_t        state_q;
	logic [6:0]    num_keys_q;
	logic [CW-1:0] n_q, w_q, lo_q, mid_q, hi_q, l_q, r_q, k_q, i_q;
	logic          rd_mat_q, pos_ok_q, row_ok_q;
	logic [5:0]    row_q;
	logic          out_valid_q;
	ksp_pkg::rsp_t out_q;

	// memories
	logic [31:0]   key_mem [MAX_KEYS];
	logic [31:0]   elem_mem [MAX_ROWS * MAX_KEYS];
	logic [KW-1:0] scr_mem [MAX_KEYS];
	logic [31:0]   key_a_q, key_b_q, elem_q;
	logic [KW-1:0] scr_q;

	logic          accept, pos_ok, row_ok, out_free, out_load;
	logic          om_rd_en, om_wr_en, key_rd_en;
	logic [KW-1:0] om_addr_a, om_addr_b, om_a, om_b;
	logic [EAW-1:0] ld_addr, rd_addr;
	logic          take_left;
	logic [CW-1:0] seg_mid, seg_hi, lo_next, w_next, n_sat;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	// a read or sort result enters the result register this cycle
	assign out_load = (state_q == ST_RD_DAT || state_q == ST_SORT_DONE) && out_free;
	assign pos_ok   = 32'(in_beat.position) < MAX_KEYS;
	assign row_ok   = 32'(in_beat.row_index) < MAX_ROWS;
	assign n_sat    = (32'(num_keys_q) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(num_keys_q);

	assign ld_addr = EAW'(32'(in_beat.row_index) * MAX_KEYS + 32'(in_beat.position));
	assign rd_addr = EAW'(32'(row_q) * MAX_KEYS + 32'(om_a));

	assign om_rd_en  = (accept && in_beat.func == ksp_pkg::FUNC_READ) || state_q == ST_M_OM;
	assign om_addr_a = (state_q == ST_IDLE) ? KW'(in_beat.position) : KW'(l_q);
	assign om_addr_b = KW'(r_q);
	assign om_wr_en  = (state_q == ST_CP_WR);
	assign key_rd_en = (state_q == ST_RD_OM) || (state_q == ST_M_KEY);

	assign seg_mid = (lo_q + w_q > n_q) ? n_q : lo_q + w_q;
	assign seg_hi  = (lo_q + CW'(w_q << 1) > n_q) ? n_q : lo_q + CW'(w_q << 1);
	assign lo_next = lo_q + CW'(w_q << 1);
	assign w_next  = CW'(w_q << 1);

	// stable merge: equal keys take the left run first
	always_comb begin
		if (l_q >= mid_q) begin
			take_left = 1'b0;
		end else if (r_q >= hi_q) begin
			take_left = 1'b1;
		end else begin
			take_left = $signed(key_a_q) <= $signed(key_b_q);
		end
	end

	ksp_order_map #(.N(MAX_KEYS), .AW(KW)) u_order_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (om_rd_en),
		.rd_addr_a (om_addr_a),
		.rd_addr_b (om_addr_b),
		.rd_data_a (om_a),
		.rd_data_b (om_b),
		.wr_en     (om_wr_en),
		.wr_addr   (KW'(i_q)),
		.wr_data   (scr_q)
	);

	always_ff @(posedge clk) begin
		if (accept && in_beat.func == ksp_pkg::FUNC_LOAD_KEY && pos_ok) begin
			key_mem[KW'(in_beat.position)] <= in_beat.value;
		end
		if (key_rd_en) begin
			key_a_q <= key_mem[om_a];
			key_b_q <= key_mem[om_b];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_beat.func == ksp_pkg::FUNC_LOAD_ELEM && pos_ok && row_ok) begin
			elem_mem[ld_addr] <= in_beat.value;
		end
		if (state_q == ST_RD_OM) begin
			elem_q <= elem_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_M_CMP) begin
			scr_mem[KW'(k_q)] <= take_left ? om_a : om_b;
		end
		if (state_q == ST_CP_RD) begin
			scr_q <= scr_mem[KW'(i_q)];
		end
	end

	// configuration: num_rows does not affect results and is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_keys_q <= 7'd64;
		end else if (cfg_we && cfg_index == ksp_pkg::CFG_NUM_KEYS) begin
			num_keys_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one the receiver took
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q    <= in_beat.row_index;
						rd_mat_q <= in_beat.read_matrix;
						pos_ok_q <= pos_ok;
						row_ok_q <= row_ok;
						unique case (in_beat.func)
							ksp_pkg::FUNC_SORT: state_q <= ST_SORT_INIT;
							ksp_pkg::FUNC_READ: state_q <= ST_RD_OM;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD_OM: state_q <= ST_RD_DAT;
				ST_RD_DAT: begin
					if (out_free) begin
						out_q.sort_done <= 1'b0;
						if (!pos_ok_q) begin
							out_q.data <= '0;
						end else if (!rd_mat_q) begin
							out_q.data <= key_a_q;
						end else begin
							out_q.data <= row_ok_q ? elem_q : '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SORT_INIT: begin
					n_q  <= n_sat;
					w_q  <= CW'(1);
					lo_q <= '0;
					state_q <= (n_sat < CW'(2)) ? ST_SORT_DONE : ST_SEG;
				end
				ST_SEG: begin
					mid_q <= seg_mid;
					hi_q  <= seg_hi;
					l_q   <= lo_q;
					r_q   <= seg_mid;
					k_q   <= lo_q;
					state_q <= ST_M_OM;
				end
				ST_M_OM:  state_q <= ST_M_KEY;
				ST_M_KEY: state_q <= ST_M_CMP;
				ST_M_CMP: begin
					if (take_left) begin
						l_q <= l_q + CW'(1);
					end else begin
						r_q <= r_q + CW'(1);
					end
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) >= hi_q) begin
						lo_q <= lo_next;
						if (lo_next >= n_q) begin
							i_q     <= '0;
							state_q <= ST_CP_RD;
						end else begin
							state_q <= ST_SEG;
						end
					end else begin
						state_q <= ST_M_OM;
					end
				end
				ST_CP_RD: state_q <= ST_CP_WR;
				ST_CP_WR: begin
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) >= n_q) begin
						w_q  <= w_next;
						lo_q <= '0;
						state_q <= (w_next >= n_q) ? ST_SORT_DONE : ST_SEG;
					end else begin
						state_q <= ST_CP_RD;
					end
				end
				ST_SORT_DONE: begin
					if (out_free) begin
						out_q.data      <= '0;
						out_q.sort_done <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

`ifndef SYNTHESIS
	a_sort_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_beat.func == ksp_pkg::FUNC_SORT |=> !in_ready)
		else $error("sort accepted but input still ready");
	a_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M_CMP |-> k_q < hi_q && l_q <= mid_q && r_q <= hi_q)
		else $error("merge index out of segment");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.sort_done |-> out_beat.data == 32'sd0)
		else $error("sort completion beat carries data");
`endif

endmodule
